[design/serial_command_line_parser_assert.svh]
// ----------------------------------------------------------------------------
// Serial command line parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_LINE_PARSER_ASSERT_SVH
`define SERIAL_COMMAND_LINE_PARSER_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define SCP_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("serial command line parser: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent
`define SCP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("serial command line parser: next-cycle check failed");

`endif

[design/scp_pkg.sv]
// ----------------------------------------------------------------------------
// Serial command line parser package
// Byte codes, event and command codes, keyword table and the keyword matcher.
// ----------------------------------------------------------------------------
package scp_pkg;

	// Default line capacity in characters
	localparam int LINE_CHARS_DEF = 16;

	// Keyword table geometry
	localparam int KEY_COUNT = 11;
	localparam int KEY_MAX   = 4;
	localparam int KEY_IDX_W = $clog2(KEY_MAX);

	// Control bytes
	localparam logic [7:0] BYTE_CR  = 8'd13;
	localparam logic [7:0] BYTE_BS  = 8'h08;
	localparam logic [7:0] BYTE_DEL = 8'd127;

	typedef logic [6:0] char_t;
	typedef logic [KEY_MAX-1:0][6:0] key_chars_t;

	// Per-byte event reported with each result
	typedef enum logic [2:0] {
		EV_STORED      = 3'd0,
		EV_ERASED      = 3'd1,
		EV_ERASE_EMPTY = 3'd2,
		EV_REJECTED    = 3'd3,
		EV_OVERFLOW    = 3'd4,
		EV_COMMAND     = 3'd5,
		EV_EMPTY_LINE  = 3'd6,
		EV_UNKNOWN     = 3'd7
	} event_t;

	// Command codes; keyword k of the table reports k + 1
	localparam logic [3:0] CMD_NONE = 4'd0;

	// Keyword text, first character in entry 0, unused tail zero
	localparam logic [6:0] KEY_TEXT [KEY_COUNT][KEY_MAX] = '{
		'{7'h48, 7'h45, 7'h4C, 7'h50},  // HELP
		'{7'h54, 7'h45, 7'h53, 7'h54},  // TEST
		'{7'h53, 7'h54, 7'h4F, 7'h50},  // STOP
		'{7'h4C, 7'h4F, 7'h41, 7'h44},  // LOAD
		'{7'h41, 7'h44, 7'h43, 7'h00},  // ADC
		'{7'h42, 7'h41, 7'h54, 7'h00},  // BAT
		'{7'h52, 7'h53, 7'h54, 7'h00},  // RST
		'{7'h49, 7'h4E, 7'h46, 7'h4F},  // INFO
		'{7'h4C, 7'h56, 7'h33, 7'h00},  // LV3
		'{7'h4C, 7'h56, 7'h32, 7'h00},  // LV2
		'{7'h4E, 7'h45, 7'h58, 7'h54}   // NEXT
	};
	localparam logic [2:0] KEY_LEN [KEY_COUNT] = '{
		3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd4
	};

	// Fold a to z to upper case, leave everything else
	function automatic char_t fold_upper(input char_t c);
		char_t r;
		r = c;
		if (c >= 7'h61 && c <= 7'h7A) begin
			r = c - 7'd32;
		end
		return r;
	endfunction

	// Return the command code of the first matching keyword, CMD_NONE if none.
	// short_len is the line length, or zero when the line is longer than KEY_MAX.
	function automatic logic [3:0] match_cmd(input key_chars_t chars,
			input logic [2:0] short_len);
		logic [3:0] cmd;
		logic       same;
		cmd = CMD_NONE;
		for (int k = KEY_COUNT - 1; k >= 0; k--) begin
			same = (short_len == KEY_LEN[k]);
			for (int i = 0; i < KEY_MAX; i++) begin
				if (i < int'(KEY_LEN[k]) && fold_upper(chars[i]) != KEY_TEXT[k][i]) begin
					same = 1'b0;
				end
			end
			if (same) begin
				cmd = 4'(k + 1);
			end
		end
		return cmd;
	endfunction

endpackage

[design/serial_command_line_parser.sv]
// An accepted byte is held in the input register, then its result is loaded into
//   the result register, which drives m_axis_tvalid.
// Throughput: one byte per cycle; the input register and result register each
//   hold one item, and the line state is updated in the single stage between them.
// Reset: arst_n clears the line length, both valid flags and sets echo enable to 1.
// The output register stalls the input stage only while a result waits unclaimed.
// ----------------------------------------------------------------------------
// Serial command line parser
// Collects console bytes into a line, handles erase, and on carriage return
// matches the line against fixed keywords and reports a command or error.
// ----------------------------------------------------------------------------
module serial_command_line_parser
	import scp_pkg::*;
#(
	parameter int LINE_CHARS = LINE_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_wdata,        // echo_enable
	// received bytes
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,     // [7:0] rx_byte
	// results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,     // [7:0] echo_byte, [10:8] event_code,
	                                      // [14:11] command_code, [15] zero
	output logic        m_axis_tuser      // echo_valid
);

	localparam int LEN_W = $clog2(LINE_CHARS + 1);

	logic             echo_en_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             valid_s2;
	logic             echo_s2;
	logic [7:0]       byte_s2;
	event_t           event_s2;
	logic [3:0]       cmd_s2;
	logic [LEN_W-1:0] len_q;
	key_chars_t       line_q;

	logic             advance;
	logic             is_cr;
	logic             is_erase;
	logic             is_print;
	logic             full;
	logic [2:0]       short_len;
	logic [3:0]       match;
	event_t           event_d;
	logic [3:0]       cmd_d;
	logic [LEN_W-1:0] len_d;
	logic             store_en;

	// Hold the echo enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_en_q <= 1'b1;
		end else if (cfg_we) begin
			echo_en_q <= cfg_wdata;
		end
	end

	// Advance the input stage when the result register is free or being drained
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Classify the byte and compute the event and next line length
	assign is_cr     = (byte_s1 == BYTE_CR);
	assign is_erase  = (byte_s1 == BYTE_BS) || (byte_s1 == BYTE_DEL);
	assign is_print  = (byte_s1 >= 8'd1) && (byte_s1 <= 8'd126);
	assign full      = (len_q == LEN_W'(LINE_CHARS));
	assign short_len = (len_q <= LEN_W'(KEY_MAX)) ? 3'(len_q) : 3'd0;
	assign match     = match_cmd(line_q, short_len);

	always_comb begin
		event_d  = EV_OVERFLOW;
		cmd_d    = CMD_NONE;
		len_d    = len_q;
		store_en = 1'b0;
		if (is_cr) begin
			len_d = '0;
			if (len_q == '0) begin
				event_d = EV_EMPTY_LINE;
			end else if (match != CMD_NONE) begin
				event_d = EV_COMMAND;
				cmd_d   = match;
			end else begin
				event_d = EV_UNKNOWN;
			end
		end else if (is_erase) begin
			if (len_q != '0) begin
				len_d   = len_q - 1'b1;
				event_d = EV_ERASED;
			end else begin
				event_d = EV_ERASE_EMPTY;
			end
		end else if (!full) begin
			if (is_print) begin
				len_d    = len_q + 1'b1;
				event_d  = EV_STORED;
				store_en = 1'b1;
			end else begin
				event_d = EV_REJECTED;
			end
		end
	end

	// Update the line length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (advance) begin
			len_q <= len_d;
		end
	end

	// Keep only the leading characters; longer lines never match a keyword
	always_ff @(posedge clk) begin
		if (advance && store_en && len_q < LEN_W'(KEY_MAX)) begin
			line_q[len_q[KEY_IDX_W-1:0]] <= byte_s1[6:0];
		end
	end

	// Load the result register, drop valid once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			echo_s2  <= echo_en_q;
			byte_s2  <= byte_s1;
			event_s2 <= event_d;
			cmd_s2   <= cmd_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = echo_s2;
	assign m_axis_tdata  = {1'b0, cmd_s2, event_s2, byte_s2};

`include "serial_command_line_parser_assert.svh"

	`SCP_ASSERT_SAME(a_len_bound, 1'b1, len_q <= LEN_W'(LINE_CHARS))
	`SCP_ASSERT_SAME(a_cmd_only_on_command, valid_s2 && cmd_s2 != CMD_NONE,
		event_s2 == EV_COMMAND)
	`SCP_ASSERT_NEXT(a_cr_clears_line, advance && is_cr, len_q == '0)
	`SCP_ASSERT_NEXT(a_store_grows_line, advance && store_en,
		len_q == $past(len_q) + 1'b1)

endmodule

[tb/sv/tb_serial_command_line_parser.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial command line parser testbench
// Streams console bytes into the parser and checks every result against a
// line-buffer predictor kept in the bench: directed control bytes, keyword
// edits and full-line handling, a long output stall, then random keyword
// lines, noisy lines and byte bursts with echo switched on and off.
// ----------------------------------------------------------------------------
module tb_serial_command_line_parser;
	import scp_pkg::*;

	localparam int LINE_CHARS    = LINE_CHARS_DEF;
	localparam int KEYWORD_COUNT = 11;
	localparam int IDLE_PERCENT  = 29;

	// One expected result, fields as the parser reports them
	typedef struct packed {
		logic       echo_on;
		logic [7:0] echo_byte;
		event_t     ev;
		logic [3:0] cmd;
	} line_result_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic        cfg_wdata     = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] rx_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;            // [7:0] echo_byte, [10:8] event_code,
	                                      // [14:11] command_code, [15] zero
	logic        m_axis_tuser;            // echo_valid

	// Predictor state
	logic [6:0]  line_chars [LINE_CHARS];
	int          line_len = 0;
	logic        echo_on  = 1'b1;

	line_result_t line_results [$];
	line_result_t want;
	int          errors        = 0;
	int          bytes_sent    = 0;
	int          results_seen  = 0;
	int          commands_seen = 0;
	int          overflows_seen = 0;
	bit          gaps_on       = 1'b0;
	int          stall_ticket  = 0;
	int          stall_cycles  = 0;

	serial_command_line_parser #(
		.LINE_CHARS(LINE_CHARS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("serial_command_line_parser test failed");
		$finish;
	end

	// Keyword k reports command code k + 1
	function automatic string keyword_text(input int k);
		case (k)
			0:       return "HELP";
			1:       return "TEST";
			2:       return "STOP";
			3:       return "LOAD";
			4:       return "ADC";
			5:       return "BAT";
			6:       return "RST";
			7:       return "INFO";
			8:       return "LV3";
			9:       return "LV2";
			default: return "NEXT";
		endcase
	endfunction

	// Advance the line buffer by one byte and return the result it causes
	function automatic line_result_t parse_byte(input logic [7:0] b);
		line_result_t r;
		string        kw;
		logic [7:0]   ch;
		logic         hit;
		r.echo_on   = echo_on;
		r.echo_byte = b;
		r.cmd       = CMD_NONE;
		r.ev        = EV_STORED;
		if (b == BYTE_CR) begin
			if (line_len == 0) begin
				r.ev = EV_EMPTY_LINE;
			end else begin
				// first keyword of equal length whose letters match, case folded
				for (int k = 0; k < KEYWORD_COUNT; k++) begin
					kw = keyword_text(k);
					if (r.cmd == CMD_NONE && kw.len() == line_len) begin
						hit = 1'b1;
						for (int i = 0; i < kw.len(); i++) begin
							ch = {1'b0, line_chars[i]};
							if (ch >= "a" && ch <= "z") begin
								ch = ch - 8'd32;
							end
							if (ch != kw[i]) begin
								hit = 1'b0;
							end
						end
						if (hit) begin
							r.cmd = 4'(k + 1);
						end
					end
				end
				r.ev = (r.cmd != CMD_NONE) ? EV_COMMAND : EV_UNKNOWN;
			end
			foreach (line_chars[i]) line_chars[i] = '0;
			line_len = 0;
		end else if (b == BYTE_BS || b == BYTE_DEL) begin
			if (line_len != 0) begin
				line_len--;
				line_chars[line_len] = '0;
				r.ev = EV_ERASED;
			end else begin
				r.ev = EV_ERASE_EMPTY;
			end
		end else if (line_len < LINE_CHARS) begin
			// storable bytes are 1 to 126
			if (b >= 8'd1 && b <= 8'd126) begin
				line_chars[line_len] = b[6:0];
				line_len++;
				r.ev = EV_STORED;
			end else begin
				r.ev = EV_REJECTED;
			end
		end else begin
			r.ev = EV_OVERFLOW;
		end
		return r;
	endfunction

	// Offer one byte, with random gaps ahead of it, and predict on transfer
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		line_results.push_back(parse_byte(b));
		bytes_sent++;
	endtask

	// Drop valid and hold until every expected result has come back
	task automatic wait_drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (line_results.size() != 0) @(posedge clk);
	endtask

	// Write the echo register once the parser is idle
	task automatic set_echo(input logic value);
		wait_drain();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		echo_on = value;
	endtask

	function automatic logic [7:0] printable_byte();
		return 8'($urandom_range(8'h7E, 8'h20));
	endfunction

	function automatic logic [7:0] erase_byte();
		return $urandom_range(1) ? BYTE_BS : BYTE_DEL;
	endfunction

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i]);
		end
	endtask

	// Keyword in random case, with typos fixed by erase and an occasional flaw
	task automatic send_keyword_line();
		string      kw;
		logic [7:0] c;
		kw = keyword_text($urandom_range(KEYWORD_COUNT - 1));
		for (int i = 0; i < kw.len(); i++) begin
			c = kw[i];
			if ($urandom_range(5) == 0) begin
				send_byte(printable_byte());
				send_byte(erase_byte());
			end
			if (c >= "A" && c <= "Z" && $urandom_range(1)) begin
				c = c | 8'h20;
			end
			send_byte(c);
		end
		case ($urandom_range(9))
			0: send_byte(printable_byte());
			1: send_byte(erase_byte());
			2: begin
				send_byte(erase_byte());
				send_byte(printable_byte());
			end
			default: ;
		endcase
		send_byte(BYTE_CR);
	endtask

	// Mixed line of printable, control and invalid bytes, up to max_len bytes before the CR
	task automatic send_noisy_line(input int max_len);
		int n;
		int pick;
		n = $urandom_range(max_len);
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				send_byte(printable_byte());
			end else if (pick < 85) begin
				send_byte(8'($urandom_range(31, 1)));
			end else if (pick < 92) begin
				send_byte(erase_byte());
			end else begin
				send_byte(8'($urandom_range(8'hFF, 8'h80)));
			end
		end
		send_byte(BYTE_CR);
	endtask

	// Hand out tready, with random gaps and a counted hold-off on request
	initial begin
		int stall_taken;
		int hold_left;
		stall_taken = 0;
		hold_left   = 0;
		forever begin
			@(negedge clk);
			if (stall_ticket != stall_taken) begin
				stall_taken = stall_ticket;
				hold_left   = stall_cycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string what, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
			errors++;
		end
	endtask

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (line_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
					$time, m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				want = line_results.pop_front();
				check_field("echo_valid", want.echo_on, m_axis_tuser);
				check_field("echo_byte", want.echo_byte, m_axis_tdata[7:0]);
				check_field("event_code", want.ev, m_axis_tdata[10:8]);
				check_field("command_code", want.cmd, m_axis_tdata[14:11]);
				check_field("pad bit", 0, m_axis_tdata[15]);
				results_seen++;
				if (want.ev == EV_COMMAND) commands_seen++;
				if (want.ev == EV_OVERFLOW) overflows_seen++;
			end
		end
	end

	// Erase and terminate on an empty line
	task automatic test_empty_line_controls();
		send_byte(BYTE_BS);
		send_byte(BYTE_DEL);
		send_byte(BYTE_CR);
	endtask

	// Mixed-case keyword with a wrong letter erased and retyped
	task automatic test_keyword_edit();
		send_text("hElQ");
		send_byte(BYTE_DEL);
		send_byte("p");
		send_byte(BYTE_CR);
	endtask

	// Invalid bytes, storable extremes, then overflow, erase and end on a full line
	task automatic test_byte_limits_and_full_line();
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'h7E);
		for (int i = 2; i < LINE_CHARS; i++) begin
			send_byte(8'("a" + i));
		end
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte("A");
		send_byte(BYTE_BS);
		send_byte("B");
		send_byte(BYTE_CR);
	endtask

	// Hold the output off for a long stretch while bytes keep coming
	task automatic test_output_hold();
		stall_cycles = 300;
		stall_ticket++;
		repeat (40) begin
			if ($urandom_range(3) == 0) send_byte(BYTE_CR);
			else send_byte(printable_byte());
		end
		wait_drain();
	endtask

	// Random keyword lines, noisy lines, full-line bursts and raw byte noise
	task automatic test_random_traffic(input logic echo_value, input bit with_gaps,
			input int byte_count);
		int target;
		int pick;
		set_echo(echo_value);
		gaps_on = with_gaps;
		target  = bytes_sent + byte_count;
		while (bytes_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				send_keyword_line();
			end else if (pick < 72) begin
				send_noisy_line(8);
			end else if (pick < 82) begin
				send_noisy_line(LINE_CHARS + 6);
			end else begin
				repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(255)));
			end
		end
		wait_drain();
	endtask

	initial begin
		foreach (line_chars[i]) line_chars[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_line_controls();
		test_keyword_edit();
		test_byte_limits_and_full_line();
		test_output_hold();
		test_random_traffic(1'b0, 1'b0, 300);
		test_random_traffic(1'b1, 1'b1, 600);
		test_random_traffic(1'b0, 1'b1, 500);
		test_random_traffic(1'b1, 1'b1, 400);

		wait_drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d bytes, checked %0d results: %0d commands, %0d overflows,",
			bytes_sent, results_seen, commands_seen, overflows_seen);
		$display("echo on and off, random gaps on both sides and a long output hold-off");
		if (errors == 0) begin
			$display("serial_command_line_parser test passed");
		end else begin
			$display("serial_command_line_parser test failed");
		end
		$finish;
	end

endmodule
